### rtl/sfr_pkg.sv
// Shared constants, status codes and the bytewise CRC16-Modbus update
// for the sync frame receiver. No dependencies.
package sfr_pkg;

	localparam logic [7:0]  SYNC_FIRST   = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND  = 8'h55;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [7:0]  LEN_EXPECTED = 8'd9;

	// Frame positions
	localparam logic [3:0] POS_HUNT    = 4'd0;
	localparam logic [3:0] POS_SYNC2   = 4'd1;
	localparam logic [3:0] POS_LENGTH  = 4'd2;
	localparam logic [3:0] POS_W1_LO   = 4'd3;
	localparam logic [3:0] POS_W1_HI   = 4'd6;
	localparam logic [3:0] POS_W2_LO   = 4'd7;
	localparam logic [3:0] POS_W2_HI   = 4'd10;
	localparam logic [3:0] POS_FLAG    = 4'd11;
	localparam logic [3:0] POS_CRC_LO  = 4'd12;
	localparam logic [3:0] POS_CRC_HI  = 4'd13;

	// Result status codes
	localparam logic [1:0] ST_GOOD    = 2'd0;
	localparam logic [1:0] ST_BAD_LEN = 2'd1;
	localparam logic [1:0] ST_BAD_CRC = 2'd2;
	localparam logic [1:0] ST_BAD_PAY = 2'd3;

	// One byte through the reflected CRC16-Modbus register, eight bit steps.
	function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic exp_all_ones(input logic [31:0] w);
		return &w[30:23];
	endfunction

endpackage

### rtl/sync_frame_receiver_crc16.sv
// Sync frame receiver: AA 55 hunt, 12-byte frame capture, CRC16-Modbus check.
// Depends on sfr_pkg.
//
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) takes one serial byte per beat.
//   Output channel (out_valid, out_stall, status and frame fields) delivers one
//   beat per complete frame, on the frame's fourteenth byte, counting from the AA before 55.
//   A byte goes through an input register and then updates the frame state;
//   the closing byte of a frame loads the result register, and out_valid rises
//   as that register is loaded.
//   Throughput is one byte per cycle while in_stall is low; the CRC update is one unrolled byte step.
//   When out_stall holds a waiting result, bytes that do not close a frame keep
//   flowing; a closing byte waits in the input register, and in_stall rises
//   only then, until the result beat is taken.
//   Reset (arst_n low) empties both registers, returns to the AA hunt and sets
//   the running CRC to FFFF.
//   Status: 0 good, 1 length not 9, 2 CRC mismatch, 3 bad payload (either word
//   has an all-ones exponent, or the flag is above 1), in that priority.
module sync_frame_receiver_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] first_word,
	output logic [31:0] second_word,
	output logic [7:0]  flag_byte,
	output logic [7:0]  received_length,
	output logic [15:0] received_crc,
	output logic [15:0] computed_crc
);

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic [3:0]  pos_q;
	logic [15:0] crc_q;
	logic [7:0]  length_q;
	logic [31:0] first_q;
	logic [31:0] second_q;
	logic [7:0]  flag_q;
	logic [7:0]  crc_low_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [31:0] first_word_q;
	logic [31:0] second_word_q;
	logic [7:0]  flag_byte_q;
	logic [7:0]  length_out_q;
	logic [15:0] rx_crc_q;
	logic [15:0] calc_crc_q;

	logic        closes;
	logic        out_free;
	logic        advance;
	logic [15:0] rx_crc;
	logic [1:0]  status_d;

	assign closes   = (pos_q == sfr_pkg::POS_CRC_HI);
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!closes || out_free);
	assign in_stall = valid_s1 && !advance;

	assign rx_crc = {byte_s1, crc_low_q};

	always_comb begin
		if (length_q != sfr_pkg::LEN_EXPECTED) begin
			status_d = sfr_pkg::ST_BAD_LEN;
		end else if (rx_crc != crc_q) begin
			status_d = sfr_pkg::ST_BAD_CRC;
		end else if (sfr_pkg::exp_all_ones(first_q) || sfr_pkg::exp_all_ones(second_q)
				|| flag_q > 8'd1) begin
			status_d = sfr_pkg::ST_BAD_PAY;
		end else begin
			status_d = sfr_pkg::ST_GOOD;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= sfr_pkg::POS_HUNT;
			crc_q     <= sfr_pkg::CRC_INIT;
			length_q  <= 8'd0;
			first_q   <= 32'd0;
			second_q  <= 32'd0;
			flag_q    <= 8'd0;
			crc_low_q <= 8'd0;
		end else if (advance) begin
			case (pos_q) inside
				sfr_pkg::POS_SYNC2: begin
					if (byte_s1 == sfr_pkg::SYNC_SECOND) begin
						pos_q <= sfr_pkg::POS_LENGTH;
						crc_q <= sfr_pkg::CRC_INIT;
					end else begin
						pos_q <= (byte_s1 == sfr_pkg::SYNC_FIRST)
							? sfr_pkg::POS_SYNC2 : sfr_pkg::POS_HUNT;
					end
				end
				[sfr_pkg::POS_LENGTH:sfr_pkg::POS_FLAG]: begin
					crc_q <= sfr_pkg::crc_feed(crc_q, byte_s1);
					pos_q <= pos_q + 4'd1;
					case (pos_q) inside
						sfr_pkg::POS_LENGTH: length_q <= byte_s1;
						[sfr_pkg::POS_W1_LO:sfr_pkg::POS_W1_HI]:
							first_q <= {byte_s1, first_q[31:8]};
						[sfr_pkg::POS_W2_LO:sfr_pkg::POS_W2_HI]:
							second_q <= {byte_s1, second_q[31:8]};
						default: flag_q <= byte_s1;
					endcase
				end
				sfr_pkg::POS_CRC_LO: begin
					crc_low_q <= byte_s1;
					pos_q     <= sfr_pkg::POS_CRC_HI;
				end
				sfr_pkg::POS_CRC_HI: begin
					pos_q <= sfr_pkg::POS_HUNT;
				end
				default: begin
					// hunt, including the unused positions
					pos_q <= (byte_s1 == sfr_pkg::SYNC_FIRST)
						? sfr_pkg::POS_SYNC2 : sfr_pkg::POS_HUNT;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && closes) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && closes) begin
			status_q      <= status_d;
			first_word_q  <= first_q;
			second_word_q <= second_q;
			flag_byte_q   <= flag_q;
			length_out_q  <= length_q;
			rx_crc_q      <= rx_crc;
			calc_crc_q    <= crc_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign first_word      = first_word_q;
	assign second_word     = second_word_q;
	assign flag_byte       = flag_byte_q;
	assign received_length = length_out_q;
	assign received_crc    = rx_crc_q;
	assign computed_crc    = calc_crc_q;

endmodule

### dv/tb_top.sv
// Self-checking testbench for sync_frame_receiver_crc16: byte stream in, frame results out.
// Depends on sfr_pkg and the receiver RTL. It predicts each frame result and checks
// every result beat against it, with random input idling and random back-pressure on the output.
module tb_top;

	localparam int BYTE_TARGET = 1750;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOW_LIMIT  = 10;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] first_word;
		logic [31:0] second_word;
		logic [7:0]  flag_byte;
		logic [7:0]  received_length;
		logic [15:0] received_crc;
		logic [15:0] computed_crc;
	} frame_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	frame_result_t got;

	sync_frame_receiver_crc16 dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (got.status),
		.first_word      (got.first_word),
		.second_word     (got.second_word),
		.flag_byte       (got.flag_byte),
		.received_length (got.received_length),
		.received_crc    (got.received_crc),
		.computed_crc    (got.computed_crc)
	);

	frame_result_t pending_frames[$];
	int            mismatches;
	int            bytes_sent;
	int            cycle_count;
	int            hold_cycles;
	bit            no_idle;

	// Predicted frame state
	logic [3:0]  hunt_pos;
	logic [15:0] crc_acc;
	logic [7:0]  len_seen;
	logic [31:0] word_a;
	logic [31:0] word_b;
	logic [7:0]  flag_seen;
	logic [7:0]  crc_lo_seen;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sync_frame_receiver_crc16: mismatch");
			$finish;
		end
	end

	// Reflected CRC16-Modbus, one data bit per step, LSB first.
	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = c;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = r >> 1;
			if (fb)
				r = r ^ sfr_pkg::CRC_POLY;
		end
		return r;
	endfunction

	function automatic logic exponent_saturated(input logic [31:0] w);
		return w[30:23] == 8'hFF;
	endfunction

	task automatic predict_rx_byte(input logic [7:0] b);
		frame_result_t r;
		logic [15:0]   rx_crc;
		if (hunt_pos == sfr_pkg::POS_HUNT || hunt_pos > sfr_pkg::POS_CRC_HI) begin
			hunt_pos = (b == sfr_pkg::SYNC_FIRST) ? sfr_pkg::POS_SYNC2 : sfr_pkg::POS_HUNT;
		end else if (hunt_pos == sfr_pkg::POS_SYNC2) begin
			if (b == sfr_pkg::SYNC_SECOND) begin
				hunt_pos = sfr_pkg::POS_LENGTH;
				crc_acc  = sfr_pkg::CRC_INIT;
			end else begin
				hunt_pos = (b == sfr_pkg::SYNC_FIRST) ? sfr_pkg::POS_SYNC2 : sfr_pkg::POS_HUNT;
			end
		end else if (hunt_pos <= sfr_pkg::POS_FLAG) begin
			crc_acc = crc16_step(crc_acc, b);
			if (hunt_pos == sfr_pkg::POS_LENGTH)
				len_seen = b;
			else if (hunt_pos <= sfr_pkg::POS_W1_HI)
				word_a[(hunt_pos - sfr_pkg::POS_W1_LO) * 8 +: 8] = b;
			else if (hunt_pos <= sfr_pkg::POS_W2_HI)
				word_b[(hunt_pos - sfr_pkg::POS_W2_LO) * 8 +: 8] = b;
			else
				flag_seen = b;
			hunt_pos = hunt_pos + 4'd1;
		end else if (hunt_pos == sfr_pkg::POS_CRC_LO) begin
			crc_lo_seen = b;
			hunt_pos    = sfr_pkg::POS_CRC_HI;
		end else begin
			rx_crc = {b, crc_lo_seen};
			if (len_seen != sfr_pkg::LEN_EXPECTED)
				r.status = sfr_pkg::ST_BAD_LEN;
			else if (rx_crc != crc_acc)
				r.status = sfr_pkg::ST_BAD_CRC;
			else if (exponent_saturated(word_a) || exponent_saturated(word_b)
					|| flag_seen > 8'd1)
				r.status = sfr_pkg::ST_BAD_PAY;
			else
				r.status = sfr_pkg::ST_GOOD;
			r.first_word      = word_a;
			r.second_word     = word_b;
			r.flag_byte       = flag_seen;
			r.received_length = len_seen;
			r.received_crc    = rx_crc;
			r.computed_crc    = crc_acc;
			pending_frames.push_back(r);
			hunt_pos = sfr_pkg::POS_HUNT;
		end
	endtask

	// Offer one byte after a random gap; return at the falling edge after the beat.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (in_stall);
		predict_rx_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Send the first n_bytes of a frame; the CRC is correct unless corrupted.
	task automatic send_frame(input logic [7:0] len, input logic [31:0] w1,
			input logic [31:0] w2, input logic [7:0] flag, input bit bad_crc,
			input int n_bytes);
		logic [7:0]  fb[14];
		logic [15:0] crc;
		fb[0]  = sfr_pkg::SYNC_FIRST;
		fb[1]  = sfr_pkg::SYNC_SECOND;
		fb[2]  = len;
		fb[11] = flag;
		for (int i = 0; i < 4; i++) begin
			fb[3 + i] = w1[i * 8 +: 8];
			fb[7 + i] = w2[i * 8 +: 8];
		end
		crc = sfr_pkg::CRC_INIT;
		for (int i = 2; i < 12; i++)
			crc = crc16_step(crc, fb[i]);
		if (bad_crc)
			crc = crc ^ 16'($urandom_range(1, 65535));
		fb[12] = crc[7:0];
		fb[13] = crc[15:8];
		for (int i = 0; i < n_bytes; i++)
			send_byte(fb[i]);
	endtask

	function automatic logic [31:0] rand_float_bits();
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(0, 7) == 0)
			w[30:23] = 8'hFF;
		return w;
	endfunction

	task automatic test_sync_hunt();
		// false start, lone second sync, then a run of first-sync bytes
		send_byte(sfr_pkg::SYNC_FIRST);
		send_byte(8'h12);
		send_byte(sfr_pkg::SYNC_SECOND);
		send_byte(sfr_pkg::SYNC_FIRST);
		send_byte(sfr_pkg::SYNC_FIRST);
		send_frame(sfr_pkg::LEN_EXPECTED, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b0, 14);
	endtask

	task automatic test_status_codes();
		send_frame(sfr_pkg::LEN_EXPECTED, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 8'h01, 1'b0, 14);
		send_frame(8'hFF, 32'h7F80_0000, 32'hFFFF_FFFF, 8'hFF, 1'b1, 14);
		send_frame(8'h00, 32'h3F80_0000, 32'h0000_0001, 8'h00, 1'b0, 14);
		send_frame(sfr_pkg::LEN_EXPECTED, 32'h3F80_0000, 32'h4000_0000, 8'h00, 1'b1, 14);
		send_frame(sfr_pkg::LEN_EXPECTED, 32'h7F80_0000, 32'h0000_0000, 8'h00, 1'b0, 14);
		send_frame(sfr_pkg::LEN_EXPECTED, 32'h0000_0000, 32'hFFFF_FFFF, 8'h01, 1'b0, 14);
		send_frame(sfr_pkg::LEN_EXPECTED, 32'h8000_0000, 32'h807F_FFFF, 8'h02, 1'b0, 14);
	endtask

	task automatic test_backpressure();
		no_idle     = 1'b1;
		hold_cycles = 400;
		repeat (4)
			send_frame(sfr_pkg::LEN_EXPECTED, rand_float_bits(), rand_float_bits(),
				8'($urandom_range(0, 1)), 1'b0, 14);
		no_idle = 1'b0;
	endtask

	task automatic test_random_stream();
		int kind;
		logic [7:0] len;
		logic [7:0] flag;
		while (bytes_sent < BYTE_TARGET) begin
			if ($urandom_range(0, 15) == 0)
				no_idle = ~no_idle;
			kind = $urandom_range(0, 9);
			len  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : sfr_pkg::LEN_EXPECTED;
			flag = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
			case (kind)
				7: begin
					repeat ($urandom_range(1, 6)) begin
						case ($urandom_range(0, 5))
							0, 1: send_byte(sfr_pkg::SYNC_FIRST);
							2: send_byte(sfr_pkg::SYNC_SECOND);
							default: send_byte(8'($urandom));
						endcase
					end
				end
				8: begin
					send_frame(len, rand_float_bits(), rand_float_bits(), flag, 1'b0,
						$urandom_range(1, 13));
				end
				default: begin
					if (kind == 9)
						send_byte(sfr_pkg::SYNC_FIRST);
					send_frame(len, rand_float_bits(), rand_float_bits(), flag,
						$urandom_range(0, 7) == 0, 14);
				end
			endcase
		end
		no_idle = 1'b0;
	endtask

	task automatic report_mismatch(input string what, input frame_result_t e);
		mismatches++;
		if (mismatches <= SHOW_LIMIT) begin
			$display("%s: exp st=%0d w1=%h w2=%h flag=%h len=%h rcrc=%h ccrc=%h", what,
				e.status, e.first_word, e.second_word, e.flag_byte,
				e.received_length, e.received_crc, e.computed_crc);
			$display("%s: got st=%0d w1=%h w2=%h flag=%h len=%h rcrc=%h ccrc=%h", what,
				got.status, got.first_word, got.second_word, got.flag_byte,
				got.received_length, got.received_crc, got.computed_crc);
		end
	endtask

	always @(posedge clk) begin
		frame_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frames.size() == 0) begin
				e = '0;
				report_mismatch("unexpected beat", e);
			end else begin
				e = pending_frames.pop_front();
				if (got.status !== e.status || got.first_word !== e.first_word ||
						got.second_word !== e.second_word || got.flag_byte !== e.flag_byte ||
						got.received_length !== e.received_length ||
						got.received_crc !== e.received_crc ||
						got.computed_crc !== e.computed_crc)
					report_mismatch("frame result", e);
			end
		end
	end

	// Result side: random stall per beat, plus a long hold when requested.
	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			n = no_idle ? 0 : $urandom_range(0, 13);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(out_valid && !out_stall) && hold_cycles == 0);
			@(negedge clk);
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		rx_byte     = 8'h00;
		mismatches  = 0;
		bytes_sent  = 0;
		cycle_count = 0;
		hold_cycles = 0;
		no_idle     = 1'b0;
		hunt_pos    = sfr_pkg::POS_HUNT;
		crc_acc     = sfr_pkg::CRC_INIT;
		len_seen    = 8'h00;
		word_a      = 32'h0;
		word_b      = 32'h0;
		flag_seen   = 8'h00;
		crc_lo_seen = 8'h00;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_sync_hunt();
		test_status_codes();
		test_backpressure();
		test_random_stream();

		in_valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("sync_frame_receiver_crc16: match");
		else
			$display("sync_frame_receiver_crc16: mismatch");
		$finish;
	end

endmodule

### sim.f
rtl/sfr_pkg.sv
rtl/sync_frame_receiver_crc16.sv
dv/tb_top.sv
